// ===== hdl/hst_pkg.sv =====
// Shared constants, types and CRC functions for the humidity sensor bus target core.
package hst_pkg;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_WRITE = 2'd1;
    localparam logic [1:0] EV_READ  = 2'd2;

    localparam logic [15:0] CMD_MEAS_0 = 16'h2C06;
    localparam logic [15:0] CMD_MEAS_1 = 16'h2C0D;
    localparam logic [15:0] CMD_MEAS_2 = 16'h2C10;
    localparam logic [15:0] CMD_MEAS_3 = 16'h2400;
    localparam logic [15:0] CMD_MEAS_4 = 16'h240B;
    localparam logic [15:0] CMD_MEAS_5 = 16'h2416;
    localparam logic [15:0] CMD_MEAS_6 = 16'hE000;
    localparam logic [15:0] CMD_STATUS = 16'hF32D;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] PAST_END = 8'hFF;

    localparam logic [2:0] LEN_NONE   = 3'd0;
    localparam logic [2:0] LEN_STATUS = 3'd3;
    localparam logic [2:0] LEN_MEAS   = 3'd6;
    localparam int         RESP_DEPTH = 6;
    localparam int         CMD_DEPTH  = 2;

    // Temperature: offset by 4500, span 0..17500.
    localparam logic [16:0] TEMP_OFS  = 17'd4500;
    localparam logic [15:0] TEMP_SPAN = 16'd17500;
    localparam logic [13:0] HUM_MAX   = 14'd10000;

    // raw = floor((x*13107 + c) / d) via exact reciprocal, folded into one constant product.
    // temp: d = 3500, c = 1750, shift 40; hum: d = 2000, c = 1000, shift 38
    localparam logic [41:0] TEMP_MUL = 42'd4117513981260;
    localparam logic [41:0] TEMP_ADD = 42'd549755815000;
    localparam logic [40:0] HUM_MUL  = 41'd1801412370078;
    localparam logic [40:0] HUM_ADD  = 41'd137438954000;

    typedef struct packed {
        logic [1:0]  command;
        logic        is_read;
        logic [7:0]  write_byte;
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
    } item_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] crc8_pair(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_byte(crc8_byte(CRC_INIT, hi), lo);
    endfunction

endpackage

// ===== hdl/humidity_sensor_i2c_target_core.sv =====
// Bus target core of a temperature and humidity sensor: command capture, scaling, CRC, readback.
//
//  channel | ports        | tdata (low bit up)                         | tuser (low bit up)
//  --------+--------------+--------------------------------------------+---------------------
//  in      | s_axis_*     | write_byte[8], temperature_centi[16] s,    | command[2], is_read[1]
//          |              | humidity_centi[14], 2 zero pad bits        |
//  out     | m_axis_*     | read_data[8]                               | ack[1]
//
// One request accepted per cycle unless stalled; it passes the input register, then the result register.
// Scaling (clamp and one constant multiply per code) runs ahead of the input register;
// CRC, command decode and all state updates run between the input and result registers.
// Reset clears command count, response length, read pointer and both valid bits.
// A stalled result holds the result register; the input register still fills while it is empty.
module humidity_sensor_i2c_target_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hst_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // write_byte, temperature_centi, humidity_centi
    input  logic [hst_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // command, is_read
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hst_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // read_data
    output logic [hst_pkg::M_TUSER_W-1:0]     m_axis_tuser   // ack
);

    logic signed [15:0] temp_in;
    logic signed [16:0] temp_sum;
    logic [14:0]        temp_x;
    logic [13:0]        hum_in;
    logic [13:0]        hum_x;
    logic [56:0]        temp_prod;
    logic [54:0]        hum_prod;
    hst_pkg::item_t     item_capt;

    logic               in_valid_reg, in_valid_next;
    hst_pkg::item_t     in_item_reg, in_item_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg, out_data_next;

    logic [7:0]         cmd_byte_reg [hst_pkg::CMD_DEPTH];
    logic [7:0]         cmd_byte_next [hst_pkg::CMD_DEPTH];
    logic [1:0]         cmd_cnt_reg, cmd_cnt_next;
    logic [7:0]         resp_reg [hst_pkg::RESP_DEPTH];
    logic [7:0]         resp_next [hst_pkg::RESP_DEPTH];
    logic [2:0]         resp_len_reg, resp_len_next;
    logic [2:0]         rd_ptr_reg, rd_ptr_next;

    logic               pipe_adv;
    logic               fire;
    logic               run;
    logic [15:0]        code;
    logic [7:0]         crc_temp;
    logic [7:0]         crc_hum;
    logic [7:0]         crc_zero;

    // input-side scaling
    assign temp_in  = signed'(s_axis_tdata[23:8]);
    assign temp_sum = {temp_in[15], temp_in} + signed'(hst_pkg::TEMP_OFS);
    assign hum_in   = s_axis_tdata[37:24];

    always_comb begin
        if (temp_sum[16]) begin
            temp_x = 15'd0;
        end else if (temp_sum[15:0] > hst_pkg::TEMP_SPAN) begin
            temp_x = hst_pkg::TEMP_SPAN[14:0];
        end else begin
            temp_x = temp_sum[14:0];
        end
        if (hum_in > hst_pkg::HUM_MAX) begin
            hum_x = hst_pkg::HUM_MAX;
        end else begin
            hum_x = hum_in;
        end
    end

    assign temp_prod = 57'(temp_x) * 57'(hst_pkg::TEMP_MUL) + 57'(hst_pkg::TEMP_ADD);
    assign hum_prod  = 55'(hum_x) * 55'(hst_pkg::HUM_MUL) + 55'(hst_pkg::HUM_ADD);

    always_comb begin
        item_capt.command    = s_axis_tuser[1:0];
        item_capt.is_read    = s_axis_tuser[2];
        item_capt.write_byte = s_axis_tdata[7:0];
        item_capt.raw_temp   = temp_prod[55:40];
        item_capt.raw_hum    = hum_prod[53:38];
    end

    // handshake
    assign pipe_adv      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || pipe_adv;
    assign fire          = in_valid_reg && pipe_adv;

    assign crc_temp = hst_pkg::crc8_pair(in_item_reg.raw_temp[15:8], in_item_reg.raw_temp[7:0]);
    assign crc_hum  = hst_pkg::crc8_pair(in_item_reg.raw_hum[15:8], in_item_reg.raw_hum[7:0]);
    assign crc_zero = hst_pkg::crc8_pair(8'h00, 8'h00);

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_byte_next  = cmd_byte_reg;
        cmd_cnt_next   = cmd_cnt_reg;
        resp_next      = resp_reg;
        resp_len_next  = resp_len_reg;
        rd_ptr_next    = rd_ptr_reg;
        run            = 1'b0;
        code           = {cmd_byte_reg[0], cmd_byte_reg[1]};

        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
            in_item_next  = item_capt;
        end
        if (pipe_adv) begin
            out_valid_next = in_valid_reg;
        end

        if (fire) begin
            out_data_next = 8'h00;
            case (in_item_reg.command)
                hst_pkg::EV_START: begin
                    if (in_item_reg.is_read) begin
                        rd_ptr_next = 3'd0;
                    end else begin
                        cmd_cnt_next = 2'd0;
                    end
                end
                hst_pkg::EV_WRITE: begin
                    if (cmd_cnt_reg == 2'd0) begin
                        cmd_byte_next[0] = in_item_reg.write_byte;
                        cmd_cnt_next     = 2'd1;
                    end else if (cmd_cnt_reg == 2'd1) begin
                        cmd_byte_next[1] = in_item_reg.write_byte;
                        cmd_cnt_next     = 2'd2;
                    end
                    run  = (cmd_cnt_next == 2'd2);
                    code = {cmd_byte_next[0], cmd_byte_next[1]};
                end
                hst_pkg::EV_READ: begin
                    if (rd_ptr_reg < resp_len_reg) begin
                        out_data_next = resp_reg[rd_ptr_reg];
                        rd_ptr_next   = rd_ptr_reg + 3'd1;
                    end else begin
                        out_data_next = hst_pkg::PAST_END;
                    end
                end
                default: begin
                end
            endcase
        end

        if (run) begin
            rd_ptr_next = 3'd0;
            if (code inside {hst_pkg::CMD_MEAS_0, hst_pkg::CMD_MEAS_1, hst_pkg::CMD_MEAS_2,
                             hst_pkg::CMD_MEAS_3, hst_pkg::CMD_MEAS_4, hst_pkg::CMD_MEAS_5,
                             hst_pkg::CMD_MEAS_6}) begin
                resp_next[0]  = in_item_reg.raw_temp[15:8];
                resp_next[1]  = in_item_reg.raw_temp[7:0];
                resp_next[2]  = crc_temp;
                resp_next[3]  = in_item_reg.raw_hum[15:8];
                resp_next[4]  = in_item_reg.raw_hum[7:0];
                resp_next[5]  = crc_hum;
                resp_len_next = hst_pkg::LEN_MEAS;
            end else if (code == hst_pkg::CMD_STATUS) begin
                resp_next[0]  = 8'h00;
                resp_next[1]  = 8'h00;
                resp_next[2]  = crc_zero;
                resp_len_next = hst_pkg::LEN_STATUS;
            end else begin
                resp_len_next = hst_pkg::LEN_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_cnt_reg   <= 2'd0;
            resp_len_reg  <= hst_pkg::LEN_NONE;
            rd_ptr_reg    <= 3'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cmd_cnt_reg   <= cmd_cnt_next;
            resp_len_reg  <= resp_len_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
        cmd_byte_reg <= cmd_byte_next;
        resp_reg     <= resp_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = 1'b1;

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ptr_reg <= resp_len_reg)
        else $error("read pointer beyond response length");

    a_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_len_reg == hst_pkg::LEN_NONE || resp_len_reg == hst_pkg::LEN_STATUS ||
        resp_len_reg == hst_pkg::LEN_MEAS)
        else $error("illegal response length");

    a_cnt_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_cnt_reg <= 2'd2)
        else $error("command byte count overflow");

    a_run_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.command == hst_pkg::EV_WRITE && cmd_cnt_reg != 2'd0
        |=> rd_ptr_reg == 3'd0)
        else $error("command run did not rewind read pointer");

endmodule
